// File: hw/rtl/hbsp_pkg.sv
// ----------------------------------------------------------------------------
// hbsp_pkg
// Shared constants and types of the eight-slot block probe unit.
// ----------------------------------------------------------------------------
package hbsp_pkg;

  localparam int LOG_MAX_BLOCKS = 10;
  localparam int HASH_BITS      = 32;
  localparam int STAMP_BITS     = 7;
  localparam int GROUP_ID_BITS  = 32;

  localparam int SLOTS    = 8;
  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 8;
  localparam int ROW_W    = SLOTS * STATUS_W;
  localparam int BLK_W    = LOG_MAX_BLOCKS;
  localparam int ROWS     = 1 << BLK_W;
  localparam int ENTRY_W  = BLK_W + SLOT_W;
  localparam int ENTRIES  = 1 << ENTRY_W;
  localparam int CFG_W    = 4;
  localparam int SHIFT_W  = HASH_BITS + BLK_W;

  localparam logic [STATUS_W-1:0] EMPTY_MARK = 8'h80;
  localparam logic [SLOT_W-1:0]   LAST_SLOT  = 3'd7;

  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [BLK_W-1:0]         blk_t;
  typedef logic [STAMP_BITS-1:0]    stamp_t;
  typedef logic [GROUP_ID_BITS-1:0] group_t;

  // Outcome of comparing one block row against a stamp.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } sel_t;

endpackage

// File: hw/rtl/hbsp_status_mem.sv
// ----------------------------------------------------------------------------
// hbsp_status_mem
// Status store: one row of eight status bytes per block, byte-lane writes,
// one registered read port.
// ----------------------------------------------------------------------------
module hbsp_status_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  hbsp_pkg::blk_t            wr_row,
  input  logic [hbsp_pkg::SLOTS-1:0] wr_be,
  input  hbsp_pkg::row_t            wr_data,
  input  logic                      rd_en,
  input  hbsp_pkg::blk_t            rd_row,
  output hbsp_pkg::row_t            rd_data
);
  import hbsp_pkg::*;

  row_t mem_r [ROWS];
  row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (wr_be[i]) begin
          mem_r[wr_row][i*STATUS_W +: STATUS_W] <= wr_data[i*STATUS_W +: STATUS_W];
        end
      end
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/hbsp_group_mem.sv
// ----------------------------------------------------------------------------
// hbsp_group_mem
// Group id store: one word per slot, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hbsp_group_mem (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [hbsp_pkg::ENTRY_W-1:0]     wr_addr,
  input  hbsp_pkg::group_t                 wr_data,
  input  logic                             rd_en,
  input  logic [hbsp_pkg::ENTRY_W-1:0]     rd_addr,
  output hbsp_pkg::group_t                 rd_data
);
  import hbsp_pkg::*;

  group_t mem_r [ENTRIES];
  group_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/hbsp_slot_select.sv
// ----------------------------------------------------------------------------
// hbsp_slot_select
// Compares the eight status bytes of a block with a stamp and picks the
// first matching slot, else the first empty slot, else the last slot.
// ----------------------------------------------------------------------------
module hbsp_slot_select (
  input  hbsp_pkg::row_t   row,
  input  hbsp_pkg::stamp_t stamp,
  output hbsp_pkg::sel_t   sel
);
  import hbsp_pkg::*;

  logic [SLOTS-1:0]    hit;
  logic [SLOTS-1:0]    empty;
  logic [STATUS_W-1:0] stamp_ext;
  logic [SLOT_W-1:0]   hit_slot;
  logic [SLOT_W-1:0]   empty_slot;

  assign stamp_ext = STATUS_W'(stamp);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit[i]   = (row[i*STATUS_W +: STATUS_W] == stamp_ext);
      empty[i] = (row[i*STATUS_W +: STATUS_W] == EMPTY_MARK);
    end
  end

  // Priority encoders, lowest slot first; the last slot is the fallback.
  always_comb begin
    hit_slot   = LAST_SLOT;
    empty_slot = LAST_SLOT;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_slot = SLOT_W'(i);
      end
      if (empty[i]) begin
        empty_slot = SLOT_W'(i);
      end
    end
  end

  // A block whose last slot is occupied counts as full and reports found.
  assign sel.found = (|hit) | ~empty[SLOTS-1];
  assign sel.slot  = (|hit) ? hit_slot : empty_slot;

endmodule

// File: hw/rtl/hash_block_slot_probe_unit.sv
// ----------------------------------------------------------------------------
// hash_block_slot_probe_unit
// A probe's status row is registered when it is taken; the compare state picks the
// slot and registers it with the group id read; the output state shows the result.
// A write gives no result. A new transaction can be taken in the cycle that shows
// a result but not in the compare state, where the dependent group id is read.
// Reset: a clearing pass over all 1024 rows, one status row per cycle, marks every
// slot empty; busy stays high until it ends. The receiver cannot stall.
// ----------------------------------------------------------------------------
module hash_block_slot_probe_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic [31:0]                      in_hash,
  input  logic [9:0]                       in_block_index,
  input  logic [2:0]                       in_slot_index,
  input  logic [7:0]                       in_status_byte,
  input  logic [31:0]                      in_group_value,
  input  logic                             in_batch_last,
  output logic                             out_valid,
  output logic                             out_match_found,
  output logic [2:0]                       out_local_slot,
  output logic [31:0]                      out_group_id,
  output logic                             out_result_last,
  input  logic                             cfg_we,
  input  logic [hbsp_pkg::CFG_W-1:0]       cfg_wdata
);
  import hbsp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CMP   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  blk_t              clr_cnt_r, clr_cnt_nxt;
  logic [CFG_W-1:0]  lb_r;
  blk_t              blk_r;
  stamp_t            stamp_r;
  logic              last_r;
  logic              found_r;
  logic [SLOT_W-1:0] slot_r;

  logic              accept;
  logic              probe_go;
  logic              write_go;
  logic [CFG_W-1:0]  lb_eff;
  logic [SHIFT_W-1:0] shifted;
  blk_t              probe_blk;
  stamp_t            probe_stamp;

  logic              st_wr_en;
  blk_t              st_wr_row;
  logic [SLOTS-1:0]  st_wr_be;
  row_t              st_wr_data;
  row_t              st_rd_data;
  sel_t              sel;

  assign busy     = (state_r == S_CLEAR) || (state_r == S_CMP);
  assign accept   = start && !busy;
  assign probe_go = accept && in_req_type;
  assign write_go = accept && !in_req_type;

  // Block bits are the top bits of the hash, the stamp follows below them.
  assign lb_eff      = (lb_r > CFG_W'(LOG_MAX_BLOCKS)) ? CFG_W'(LOG_MAX_BLOCKS) : lb_r;
  assign shifted     = {{BLK_W{1'b0}}, in_hash[HASH_BITS-1:0]} << lb_eff;
  assign probe_blk   = shifted[SHIFT_W-1 -: BLK_W];
  assign probe_stamp = shifted[HASH_BITS-1 -: STAMP_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb_r <= '0;
    end else if (cfg_we) begin
      lb_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {BLK_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (probe_go) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = probe_go ? S_CMP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (probe_go) begin
      blk_r   <= probe_blk;
      stamp_r <= probe_stamp;
      last_r  <= in_batch_last;
    end
    if (state_r == S_CMP) begin
      found_r <= sel.found;
      slot_r  <= sel.slot;
    end
  end

  // The clearing pass owns the status write port until it ends.
  always_comb begin
    if (state_r == S_CLEAR) begin
      st_wr_en   = 1'b1;
      st_wr_row  = clr_cnt_r;
      st_wr_be   = {SLOTS{1'b1}};
      st_wr_data = {SLOTS{EMPTY_MARK}};
    end else begin
      st_wr_en   = write_go;
      st_wr_row  = in_block_index[BLK_W-1:0];
      st_wr_be   = SLOTS'(1) << in_slot_index;
      st_wr_data = {SLOTS{in_status_byte}};
    end
  end

  hbsp_status_mem u_status_mem (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_row  (st_wr_row),
    .wr_be   (st_wr_be),
    .wr_data (st_wr_data),
    .rd_en   (probe_go),
    .rd_row  (probe_blk),
    .rd_data (st_rd_data)
  );

  hbsp_slot_select u_slot_select (
    .row   (st_rd_data),
    .stamp (stamp_r),
    .sel   (sel)
  );

  hbsp_group_mem u_group_mem (
    .clk     (clk),
    .wr_en   (write_go),
    .wr_addr ({in_block_index[BLK_W-1:0], in_slot_index}),
    .wr_data (in_group_value[GROUP_ID_BITS-1:0]),
    .rd_en   (state_r == S_CMP),
    .rd_addr ({blk_r, sel.slot}),
    .rd_data (out_group_id)
  );

  assign out_valid       = (state_r == S_OUT);
  assign out_match_found = found_r;
  assign out_local_slot  = slot_r;
  assign out_result_last = last_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> busy)
    else $error("transaction could be taken during the clearing pass");

  a_probe_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    probe_go |=> (state_r == S_CMP))
    else $error("accepted probe did not enter the compare cycle");

  a_result_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |=> out_valid)
    else $error("compare cycle not followed by a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (write_go && (state_r == S_IDLE)) |=> !out_valid)
    else $error("write transaction produced a result");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Sends slot writes and hash probes to the eight-slot block probe unit and
// checks each lookup result against a model of the slot table kept here.
// ----------------------------------------------------------------------------
module testbench;
  import hbsp_pkg::*;

  typedef enum logic {REQ_WRITE = 1'b0, REQ_PROBE = 1'b1} req_kind_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    group_t            group;
    logic              last;
  } lookup_t;

  typedef struct {
    req_kind_t             kind;
    logic [HASH_BITS-1:0]  hash;
    blk_t                  blk;
    logic [SLOT_W-1:0]     slot;
    logic [STATUS_W-1:0]   status;
    group_t                group;
    logic                  last;
  } table_req_t;

  localparam int STALL_LIMIT  = 5000;
  localparam int REPORT_LIMIT = 10;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic                 in_req_type    = 1'b0;
  logic [31:0]          in_hash        = '0;
  logic [9:0]           in_block_index = '0;
  logic [2:0]           in_slot_index  = '0;
  logic [7:0]           in_status_byte = '0;
  logic [31:0]          in_group_value = '0;
  logic                 in_batch_last  = 1'b0;
  logic                 out_valid;
  logic                 out_match_found;
  logic [2:0]           out_local_slot;
  logic [31:0]          out_group_id;
  logic                 out_result_last;
  logic                 cfg_we         = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata      = '0;

  // Table as seen by the checking side, updated on each accepted transaction.
  row_t             table_rows [ROWS];
  group_t           table_group [ENTRIES];
  logic [CFG_W-1:0] table_log_blocks;
  lookup_t          pending_lookups [$];
  int               mismatch_count = 0;
  int               stall_cycles   = 0;

  // Table as planned by the stimulus side, updated when a transaction is sent.
  row_t             plan_rows [ROWS];
  bit               plan_group_known [ENTRIES];
  logic [CFG_W-1:0] plan_log_blocks;
  bit               idling_on;
  int               items_sent;

  hash_block_slot_probe_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_hash         (in_hash),
    .in_block_index  (in_block_index),
    .in_slot_index   (in_slot_index),
    .in_status_byte  (in_status_byte),
    .in_group_value  (in_group_value),
    .in_batch_last   (in_batch_last),
    .out_valid       (out_valid),
    .out_match_found (out_match_found),
    .out_local_slot  (out_local_slot),
    .out_group_id    (out_group_id),
    .out_result_last (out_result_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int eff_log(input logic [CFG_W-1:0] lb);
    return (lb > LOG_MAX_BLOCKS) ? LOG_MAX_BLOCKS : int'(lb);
  endfunction

  // The top bits of the hash select the block, the next seven form the stamp.
  function automatic void split_hash(input logic [HASH_BITS-1:0] h,
                                     input logic [CFG_W-1:0] lb,
                                     output blk_t blk, output stamp_t stamp);
    logic [SHIFT_W-1:0] shifted;
    shifted = {{BLK_W{1'b0}}, h} << eff_log(lb);
    blk     = shifted[SHIFT_W-1 -: BLK_W];
    stamp   = shifted[HASH_BITS-1 -: STAMP_BITS];
  endfunction

  function automatic logic [HASH_BITS-1:0] make_hash(input blk_t blk, input stamp_t stamp,
                                                     input logic [CFG_W-1:0] lb);
    logic [SHIFT_W-1:0]              key;
    logic [HASH_BITS-STAMP_BITS-1:0] filler;
    logic [HASH_BITS-1:0]            low_mask;
    int                              eff;
    eff      = eff_log(lb);
    low_mask = (32'd1 << eff) - 32'd1;
    filler   = (HASH_BITS-STAMP_BITS)'($urandom);
    key      = {blk & blk_t'(low_mask), stamp, filler};
    key      = key >> eff;
    return key[HASH_BITS-1:0] | ($urandom & low_mask);
  endfunction

  function automatic sel_t choose_slot(input row_t row, input stamp_t stamp);
    sel_t pick;
    bit   hit;
    pick.found = (row[LAST_SLOT*STATUS_W +: STATUS_W] != EMPTY_MARK);
    pick.slot  = LAST_SLOT;
    hit        = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!hit && row[s*STATUS_W +: STATUS_W] == {1'b0, stamp}) begin
        pick.slot = SLOT_W'(s);
        hit       = 1'b1;
      end
    end
    if (hit) begin
      pick.found = 1'b1;
    end else begin
      // Scanning downwards leaves the lowest empty slot as the one chosen.
      for (int s = SLOTS - 1; s >= 0; s--) begin
        if (row[s*STATUS_W +: STATUS_W] == EMPTY_MARK) pick.slot = SLOT_W'(s);
      end
    end
    return pick;
  endfunction

  task automatic note_failure(input string what, input lookup_t want, input lookup_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%s: expected found=%b slot=%0d group=%h last=%b, got found=%b slot=%0d %s",
               what, want.found, want.slot, want.group, want.last, got.found, got.slot,
               $sformatf("group=%h last=%b", got.group, got.last));
  endtask

  always @(posedge clk) begin : table_watch
    blk_t    blk;
    stamp_t  stamp;
    sel_t    pick;
    lookup_t want;
    lookup_t got;
    bit      taken;
    taken = rst_n && start && !busy;
    if (taken) begin
      if (in_req_type == REQ_PROBE) begin
        split_hash(in_hash, table_log_blocks, blk, stamp);
        pick = choose_slot(table_rows[blk], stamp);
        want = {pick.found, pick.slot, table_group[{blk, pick.slot}], in_batch_last};
        pending_lookups.push_back(want);
      end else begin
        table_rows[in_block_index][in_slot_index*STATUS_W +: STATUS_W] = in_status_byte;
        table_group[{in_block_index, in_slot_index}] = in_group_value;
      end
    end
    if (cfg_we) table_log_blocks = cfg_wdata;
    if (out_valid) begin
      got = {out_match_found, out_local_slot, out_group_id, out_result_last};
      if (pending_lookups.size() == 0) begin
        note_failure("result with no probe pending", 'x, got);
      end else begin
        want = pending_lookups.pop_front();
        if (got.found !== want.found || got.slot !== want.slot ||
            got.group !== want.group || got.last !== want.last)
          note_failure("lookup mismatch", want, got);
      end
    end
    if (taken || out_valid) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Called just after a rising edge; returns at the first edge that leaves busy low.
  task automatic hand_over(input table_req_t req);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_req_type    <= req.kind;
    in_hash        <= req.hash;
    in_block_index <= req.blk;
    in_slot_index  <= req.slot;
    in_status_byte <= req.status;
    in_group_value <= req.group;
    in_batch_last  <= req.last;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_slot(input blk_t blk, input logic [SLOT_W-1:0] slot,
                            input logic [STATUS_W-1:0] status, input group_t group);
    table_req_t req;
    req.kind   = REQ_WRITE;
    req.hash   = $urandom;
    req.blk    = blk;
    req.slot   = slot;
    req.status = status;
    req.group  = group;
    req.last   = 1'($urandom_range(0, 1));
    plan_rows[blk][slot*STATUS_W +: STATUS_W] = status;
    plan_group_known[{blk, slot}] = 1'b1;
    hand_over(req);
  endtask

  task automatic probe_hash(input logic [HASH_BITS-1:0] hash, input logic last);
    table_req_t req;
    blk_t       blk;
    stamp_t     stamp;
    sel_t       pick;
    split_hash(hash, plan_log_blocks, blk, stamp);
    pick = choose_slot(plan_rows[blk], stamp);
    // An empty slot whose group id was never stored must not be read, so give
    // it one first. Its status stays empty, so the outcome does not change.
    if (!plan_group_known[{blk, pick.slot}]) write_slot(blk, pick.slot, EMPTY_MARK, $urandom);
    req.kind   = REQ_PROBE;
    req.hash   = hash;
    req.blk    = blk_t'($urandom);
    req.slot   = SLOT_W'($urandom);
    req.status = STATUS_W'($urandom);
    req.group  = $urandom;
    req.last   = last;
    hand_over(req);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_lookups.size() != 0) @(posedge clk);
    // A write leaves no result behind, so give the last one time to land.
    repeat (4) @(posedge clk);
  endtask

  task automatic set_log_blocks(input logic [CFG_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    plan_log_blocks = value;
  endtask

  task automatic test_empty_block();
    probe_hash(make_hash('0, 7'd5, plan_log_blocks), 1'b1);
  endtask

  task automatic test_stamp_match();
    write_slot('0, 3'd2, 8'h00, $urandom);
    write_slot('0, 3'd3, 8'h7f, $urandom);
    write_slot('0, 3'd5, 8'h00, $urandom);
    probe_hash(make_hash('0, 7'h00, plan_log_blocks), 1'b0);
    probe_hash(make_hash('0, 7'h7f, plan_log_blocks), 1'b1);
    probe_hash(make_hash('0, 7'h09, plan_log_blocks), 1'b0);
  endtask

  // Status bytes above the empty mark are occupied but never match a stamp.
  task automatic test_odd_status();
    write_slot('0, 3'd0, 8'h81, 32'hffffffff);
    write_slot('0, 3'd1, 8'hff, 32'h00000000);
    probe_hash(make_hash('0, 7'h01, plan_log_blocks), 1'b1);
    probe_hash(make_hash('0, 7'h7f, plan_log_blocks), 1'b0);
  endtask

  // A block whose last slot is taken reports found even without a stamp match.
  task automatic test_full_block();
    write_slot('0, 3'd7, 8'h10, $urandom);
    probe_hash(make_hash('0, 7'h33, plan_log_blocks), 1'b1);
    write_slot('0, 3'd4, 8'hc0, $urandom);
    write_slot('0, 3'd6, 8'h7e, $urandom);
    probe_hash(make_hash('0, 7'h33, plan_log_blocks), 1'b0);
    probe_hash(make_hash('0, 7'h10, plan_log_blocks), 1'b1);
  endtask

  // Largest table, then a setting above the maximum, which must saturate.
  task automatic test_log_blocks();
    set_log_blocks(4'd10);
    write_slot(10'h3ff, 3'd7, 8'h55, $urandom);
    probe_hash(make_hash(10'h3ff, 7'h55, plan_log_blocks), 1'b1);
    probe_hash(make_hash(10'h3ff, 7'h20, plan_log_blocks), 1'b0);
    set_log_blocks(4'd15);
    probe_hash(make_hash(10'h3ff, 7'h55, plan_log_blocks), 1'b0);
    probe_hash(32'hffffffff, 1'b1);
    probe_hash(32'h00000000, 1'b0);
  endtask

  // Mostly fills a few hot blocks and probes them, often with stamps they hold;
  // the rest is fully random writes and probes anywhere in the table.
  task automatic test_random_phase(input logic [CFG_W-1:0] lb, input int count,
                                   input bit with_idling);
    int                  span;
    int                  stop_at;
    blk_t                blk;
    stamp_t              stamp;
    logic [STATUS_W-1:0] held;
    logic [STATUS_W-1:0] status;
    set_log_blocks(lb);
    idling_on = with_idling;
    span      = 1 << eff_log(lb);
    stop_at   = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 4) == 0) blk = blk_t'(span - 1);
        else blk = blk_t'($urandom_range(0, (span > 4) ? 3 : span - 1));
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 9))
            0, 1:    status = EMPTY_MARK;
            2:       status = STATUS_W'($urandom_range(8'h81, 8'hff));
            3:       status = STATUS_W'($urandom_range(0, 127));
            default: status = STATUS_W'($urandom_range(0, 7));
          endcase
          write_slot(blk, SLOT_W'($urandom_range(0, 7)), status, $urandom);
        end
        repeat ($urandom_range(1, 3)) begin
          held = plan_rows[blk][$urandom_range(0, 7)*STATUS_W +: STATUS_W];
          if (held < 8'h80 && $urandom_range(0, 1)) stamp = held[STAMP_BITS-1:0];
          else if ($urandom_range(0, 3) == 0) stamp = STAMP_BITS'($urandom_range(0, 127));
          else stamp = STAMP_BITS'($urandom_range(0, 7));
          probe_hash(make_hash(blk, stamp, lb), 1'($urandom_range(0, 1)));
        end
      end else if ($urandom_range(0, 1)) begin
        write_slot(blk_t'($urandom), SLOT_W'($urandom), STATUS_W'($urandom), $urandom);
      end else begin
        probe_hash($urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    for (int b = 0; b < ROWS; b++) begin
      table_rows[b] = {SLOTS{EMPTY_MARK}};
      plan_rows[b]  = {SLOTS{EMPTY_MARK}};
    end
    table_log_blocks = '0;
    plan_log_blocks  = '0;
    idling_on        = 1'b1;
    items_sent       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_block();
    test_stamp_match();
    test_odd_status();
    test_full_block();
    test_log_blocks();

    test_random_phase(4'd4, 100, 1'b1);
    test_random_phase(4'd0, 90, 1'b1);
    test_random_phase(4'd10, 110, 1'b1);
    test_random_phase(4'd15, 90, 1'b1);
    test_random_phase(4'd1, 100, 1'b1);
    test_random_phase(4'd7, 110, 1'b1);
    test_random_phase(4'd2, 100, 1'b1);
    test_random_phase(4'd3, 120, 1'b0);

    settle();
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
